// File: design/raid_parity_recover_unit_defines.svh
// Assertion macros shared by the RAID parity recovery unit
`ifndef RAID_PARITY_RECOVER_UNIT_DEFINES_SVH
`define RAID_PARITY_RECOVER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define RPR_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define RPR_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: design/rpr_pkg.sv
// Package: constants, codes and controller/datapath interface types
`timescale 1ns / 1ps
package rpr_pkg;

  localparam int unsigned MaxDisksDefault   = 8;
  localparam int unsigned MaxColumnsDefault = 8192;

  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned CfgDataW  = 14;
  localparam int unsigned NumDisksW = 4;
  localparam int unsigned BlkW      = 14;
  localparam int unsigned DiskBitsW = 8;
  localparam int unsigned ProdW     = 2 * BlkW;
  localparam int unsigned ColW      = ProdW + 1;
  localparam int unsigned NibW      = 4;
  localparam int unsigned BitCntW   = 3;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned DivIdxW   = $clog2(BlkW);

  localparam logic [CfgIdxW-1:0] CFG_PARITY_ODD = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_NUM_DISKS  = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_BLOCK_BITS = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_NUM_BLOCKS = 8'd3;

  localparam logic [StatusW-1:0] STATUS_ACCEPT  = 2'd0;
  localparam logic [StatusW-1:0] STATUS_VALID   = 2'd1;
  localparam logic [StatusW-1:0] STATUS_INVALID = 2'd2;
  localparam logic [StatusW-1:0] STATUS_NIBBLE  = 2'd3;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_REJECT,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_SETTLE,
    OP_PAD,
    OP_MUL,
    OP_ADDR,
    OP_DATA,
    OP_FINAL
  } dp_op_e;

  typedef struct packed {
    dp_op_e               op;
    logic                 accept;
    logic                 out_wr;
    logic [DivIdxW-1:0]   div_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic read_ok;
    logic settled;
    logic at_end;
    logic out_free;
  } dp_stat_t;

endpackage

// File: design/rpr_ctrl.sv
// Controller: sequences load, parity-disk remainder, readout and result transfer
`timescale 1ns / 1ps
module rpr_ctrl import rpr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     req_type_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_CHECK,
    S_DIV,
    S_SETTLE,
    S_ADDR,
    S_DATA,
    S_FINISH
  } state_e;

  state_e               state_q, state_d;
  logic [DivIdxW-1:0]   step_q, step_d;
  logic [BitCntW-1:0]   k_q, k_d;

  always_comb begin
    state_d        = state_q;
    step_d         = step_q;
    k_d            = k_q;
    in_ready_o     = 1'b0;
    cmd_o.op       = OP_NOP;
    cmd_o.accept   = 1'b0;
    cmd_o.out_wr   = 1'b0;
    cmd_o.div_idx  = DivIdxW'(BlkW - 1) - step_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = req_type_i ? S_CHECK : S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.op = OP_LOAD;
        state_d  = S_FINISH;
      end
      S_CHECK: begin
        if (stat_i.read_ok) begin
          cmd_o.op = OP_DIV_INIT;
          step_d   = '0;
          state_d  = S_DIV;
        end else begin
          cmd_o.op = OP_REJECT;
          state_d  = S_FINISH;
        end
      end
      S_DIV: begin
        cmd_o.op = OP_DIV_STEP;
        if (step_q == DivIdxW'(BlkW - 1)) begin
          k_d     = '0;
          state_d = S_SETTLE;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_SETTLE: begin
        if (!stat_i.settled) begin
          cmd_o.op = OP_SETTLE;
        end else if (k_q == BitCntW'(NibW)) begin
          cmd_o.op = OP_FINAL;
          state_d  = S_FINISH;
        end else if (stat_i.at_end) begin
          cmd_o.op = OP_PAD;
          k_d      = k_q + 1'b1;
        end else begin
          cmd_o.op = OP_MUL;
          state_d  = S_ADDR;
        end
      end
      S_ADDR: begin
        cmd_o.op = OP_ADDR;
        state_d  = S_DATA;
      end
      S_DATA: begin
        cmd_o.op = OP_DATA;
        k_d      = k_q + 1'b1;
        state_d  = S_SETTLE;
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.out_wr = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      k_q     <= k_d;
    end
  end

endmodule

// File: design/rpr_datapath.sv
// Datapath: config, parity check and rebuild, column store, readout position and result
`timescale 1ns / 1ps
module rpr_datapath import rpr_pkg::*; #(
  parameter int unsigned MAX_DISKS   = MaxDisksDefault,
  parameter int unsigned MAX_COLUMNS = MaxColumnsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 req_type_i,
  input  logic [DiskBitsW-1:0] disk_bits_i,
  input  logic [DiskBitsW-1:0] erased_mask_i,
  input  logic                 last_column_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [StatusW-1:0]   status_o,
  output logic [NibW-1:0]      nibble_o,
  output logic                 last_o,
  input  dp_cmd_t              cmd_i,
  output dp_stat_t             stat_o
);

  localparam int unsigned Cap = (MAX_DISKS < 8) ? MAX_DISKS : 8;
  localparam int unsigned DW  = $clog2(Cap + 1);
  localparam int unsigned DiW = $clog2(Cap);
  localparam int unsigned AW  = $clog2(MAX_COLUMNS);
  localparam int unsigned CW  = $clog2(MAX_COLUMNS + 1);

  // configuration
  logic                 parity_odd_q;
  logic [NumDisksW-1:0] num_disks_q;
  logic [BlkW-1:0]      block_bits_q;
  logic [BlkW-1:0]      num_blocks_q;
  logic [ProdW-1:0]     prod_cfg_q;

  // set and readout state
  logic [CW-1:0]        column_count_q;
  logic                 set_invalid_q;
  logic                 set_done_q;
  logic [BlkW-1:0]      read_block_q;
  logic [DW-1:0]        read_disk_q;
  logic [BlkW-1:0]      read_bit_q;
  logic                 read_done_q;
  logic [DW-1:0]        pdisk_q;
  logic                 out_valid_q;

  // item and working payload
  logic                 last_q;
  logic [DiskBitsW-1:0] disk_q;
  logic [DiskBitsW-1:0] erased_q;
  logic [ProdW-1:0]     prod_rd_q;
  logic                 col_ok_q;
  logic [Cap-1:0]       rdata_q;
  logic [NibW-1:0]      nib_q;
  logic [StatusW-1:0]   res_status_q;
  logic                 res_last_q;
  logic [StatusW-1:0]   status_q;
  logic [NibW-1:0]      nibble_q;
  logic                 last_out_q;

  logic [Cap-1:0]       mem_q [MAX_COLUMNS];

  logic [DW-1:0]        d;
  logic [Cap-1:0]       dmask, bits, erased, good0, good;
  logic                 x, multi, none, fix, col_inv;
  logic [CW-1:0]        base_cnt, new_cnt;
  logic                 base_inv, fits, inv1, inv2;
  logic                 at_end, settled;
  logic [ColW-1:0]      col;
  logic                 col_ok;
  logic [DW:0]          rem_sh, rem_next;
  logic [DW-1:0]        pinc, pwrap;

  always_comb begin
    if (num_disks_q == '0) begin
      d = DW'(1);
    end else if (num_disks_q > NumDisksW'(Cap)) begin
      d = DW'(Cap);
    end else begin
      d = num_disks_q[DW-1:0];
    end
  end

  // column check and single-erasure rebuild
  always_comb begin
    for (int i = 0; i < Cap; i++) begin
      dmask[i] = (DW'(i) < d);
    end
    bits     = disk_q[Cap-1:0] & dmask;
    erased   = erased_q[Cap-1:0] & dmask;
    good0    = bits & ~erased;
    x        = ^good0;
    none     = (erased == '0);
    multi    = ((erased & (erased - 1'b1)) != '0);
    fix      = x ^ parity_odd_q;
    good     = (!multi && !none) ? (good0 | (erased & {Cap{fix}})) : good0;
    col_inv  = multi || (none && (x != parity_odd_q));
    base_cnt = set_done_q ? '0 : column_count_q;
    base_inv = set_done_q ? 1'b0 : set_invalid_q;
    fits     = (base_cnt < CW'(MAX_COLUMNS));
    new_cnt  = fits ? base_cnt + 1'b1 : base_cnt;
    inv1     = base_inv || col_inv || !fits;
    inv2     = inv1 || (last_q && (ProdW'(new_cnt) != prod_cfg_q));
  end

  // readout position
  always_comb begin
    at_end   = (read_block_q >= num_blocks_q);
    settled  = at_end || ((read_disk_q < d) && (read_disk_q != pdisk_q) &&
                          (read_bit_q < block_bits_q));
    col      = ColW'(prod_rd_q) + ColW'(read_bit_q);
    col_ok   = (col < ColW'(MAX_COLUMNS));
    rem_sh   = {pdisk_q, read_block_q[cmd_i.div_idx]};
    rem_next = (rem_sh >= {1'b0, d}) ? rem_sh - {1'b0, d} : rem_sh;
    pinc     = pdisk_q + 1'b1;
    pwrap    = (pinc == d) ? '0 : pinc;
  end

  assign stat_o.read_ok  = set_done_q && !set_invalid_q && !read_done_q;
  assign stat_o.settled  = settled;
  assign stat_o.at_end   = at_end;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parity_odd_q <= 1'b0;
      num_disks_q  <= NumDisksW'(3);
      block_bits_q <= BlkW'(1);
      num_blocks_q <= BlkW'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PARITY_ODD: parity_odd_q <= cfg_data_i[0];
        CFG_NUM_DISKS:  num_disks_q  <= cfg_data_i[NumDisksW-1:0];
        CFG_BLOCK_BITS: block_bits_q <= cfg_data_i[BlkW-1:0];
        CFG_NUM_BLOCKS: num_blocks_q <= cfg_data_i[BlkW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_count_q <= '0;
      set_invalid_q  <= 1'b0;
      set_done_q     <= 1'b0;
      read_block_q   <= '0;
      read_disk_q    <= '0;
      read_bit_q     <= '0;
      read_done_q    <= 1'b0;
      pdisk_q        <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      case (cmd_i.op)
        OP_LOAD: begin
          column_count_q <= new_cnt;
          set_invalid_q  <= inv2;
          set_done_q     <= last_q;
          if (set_done_q) begin
            read_block_q <= '0;
            read_disk_q  <= '0;
            read_bit_q   <= '0;
            read_done_q  <= 1'b0;
          end
        end
        OP_DIV_INIT: pdisk_q <= '0;
        OP_DIV_STEP: pdisk_q <= rem_next[DW-1:0];
        OP_SETTLE: begin
          if (read_disk_q >= d) begin
            read_disk_q  <= '0;
            read_block_q <= read_block_q + 1'b1;
            pdisk_q      <= pwrap;
          end else if (read_disk_q == pdisk_q) begin
            read_disk_q <= read_disk_q + 1'b1;
          end else begin
            read_bit_q  <= '0;
            read_disk_q <= read_disk_q + 1'b1;
          end
        end
        OP_ADDR:  read_bit_q  <= read_bit_q + 1'b1;
        OP_FINAL: read_done_q <= at_end;
        default: ;
      endcase
      if (cmd_i.out_wr) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_cfg_q <= ProdW'(num_blocks_q) * ProdW'(block_bits_q);
    if (cmd_i.accept) begin
      last_q   <= last_column_i & ~req_type_i;
      disk_q   <= disk_bits_i;
      erased_q <= erased_mask_i;
    end
    case (cmd_i.op)
      OP_LOAD: begin
        res_status_q <= last_q ? (inv2 ? STATUS_INVALID : STATUS_VALID) : STATUS_ACCEPT;
        res_last_q   <= 1'b0;
        nib_q        <= '0;
        if (fits) begin
          mem_q[base_cnt[AW-1:0]] <= good;
        end
      end
      OP_REJECT: begin
        res_status_q <= STATUS_INVALID;
        res_last_q   <= 1'b1;
        nib_q        <= '0;
      end
      OP_DIV_INIT: nib_q <= '0;
      OP_MUL:      prod_rd_q <= ProdW'(read_block_q) * ProdW'(block_bits_q);
      OP_ADDR: begin
        col_ok_q <= col_ok;
        rdata_q  <= mem_q[col[AW-1:0]];
      end
      OP_PAD:  nib_q <= {nib_q[NibW-2:0], 1'b0};
      OP_DATA: nib_q <= {nib_q[NibW-2:0], col_ok_q & rdata_q[read_disk_q[DiW-1:0]]};
      OP_FINAL: begin
        res_status_q <= STATUS_NIBBLE;
        res_last_q   <= at_end;
      end
      default: ;
    endcase
    if (cmd_i.out_wr) begin
      status_q   <= res_status_q;
      nibble_q   <= nib_q;
      last_out_q <= res_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign nibble_o    = nibble_q;
  assign last_o      = last_out_q;

endmodule

// File: design/raid_parity_recover_unit.sv
// Load: LOAD stores the column and forms the result, FINISH registers it; rejected read:
// CHECK, FINISH. Read: DIV finds the parity disk (block index mod disks); per data bit
//   SETTLE, ADDR, DATA; skips (parity disk, block end, stripe end) SETTLE; pad bits PAD.
// Throughput: one item at a time; a new transfer is taken once the result is registered,
//   while that result may still wait at the output.
// Reset: async active low; config to defaults, counters and flags cleared, store undefined.
`timescale 1ns / 1ps
module raid_parity_recover_unit import rpr_pkg::*; #(
  parameter int unsigned MAX_DISKS   = MaxDisksDefault,
  parameter int unsigned MAX_COLUMNS = MaxColumnsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 req_type_i,
  input  logic [DiskBitsW-1:0] disk_bits_i,
  input  logic [DiskBitsW-1:0] erased_mask_i,
  input  logic                 last_column_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [StatusW-1:0]   status_o,
  output logic [NibW-1:0]      nibble_o,
  output logic                 last_o
);

`include "raid_parity_recover_unit_defines.svh"

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  rpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rpr_datapath #(
    .MAX_DISKS   (MAX_DISKS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .req_type_i    (req_type_i),
    .disk_bits_i   (disk_bits_i),
    .erased_mask_i (erased_mask_i),
    .last_column_i (last_column_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .nibble_o      (nibble_o),
    .last_o        (last_o),
    .cmd_i         (cmd),
    .stat_o        (stat)
  );

  `RPR_ASSERT_IMP(a_load_answer_not_last, out_valid_o && (status_o == STATUS_ACCEPT || status_o == STATUS_VALID), !last_o, "load answer flagged last")
  `RPR_ASSERT_IMP(a_nibble_zero_unless_data, out_valid_o && (status_o != STATUS_NIBBLE), nibble_o == '0, "non-data answer carries nibble bits")
  `RPR_ASSERT_NEXT(a_one_item_in_flight, in_valid_i && in_ready_o, !in_ready_o, "second transfer taken while busy")

endmodule

// File: sim/tb_raid_parity_recover_unit.sv
// Testbench for raid_parity_recover_unit: column loads, parity repair and nibble readout
`timescale 1ns / 1ps
module tb_raid_parity_recover_unit;
  import rpr_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 8_000_000;
  localparam int unsigned SETTLE_TAIL  = 200;
  localparam int unsigned RANDOM_ITEMS = 1600;
  localparam int unsigned STORE_DEPTH  = MaxColumnsDefault;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef enum int {
    COL_CLEAN,
    COL_ERASE_ONE,
    COL_ERASE_MANY,
    COL_BAD_PARITY,
    COL_NOISE
  } col_kind_e;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [NibW-1:0]    nibble;
    logic               last;
  } answer_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 req_type_i;
  logic [DiskBitsW-1:0] disk_bits_i;
  logic [DiskBitsW-1:0] erased_mask_i;
  logic                 last_column_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [StatusW-1:0]   status_o;
  logic [NibW-1:0]      nibble_o;
  logic                 last_o;

  raid_parity_recover_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .disk_bits_i   (disk_bits_i),
    .erased_mask_i (erased_mask_i),
    .last_column_i (last_column_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .nibble_o      (nibble_o),
    .last_o        (last_o)
  );

  answer_t     pending_answers[$];
  int unsigned mismatch_count = 0;
  int unsigned sent_items = 0;
  int unsigned tx_gap_max = 6;
  int unsigned rx_gap_max = 6;
  int unsigned hold_off_cycles = 0;

  // predictor state
  logic                 cfg_parity_odd;
  logic [NumDisksW-1:0] cfg_num_disks;
  logic [BlkW-1:0]      cfg_block_bits;
  logic [BlkW-1:0]      cfg_num_blocks;
  logic [7:0]           column_mirror [STORE_DEPTH];
  int unsigned          col_count;
  logic                 set_invalid;
  logic                 set_done;
  int unsigned          rd_block;
  int unsigned          rd_disk;
  int unsigned          rd_bit;
  logic                 read_done;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned active_disks();
    if (cfg_num_disks == 0) return 1;
    if (cfg_num_disks > MaxDisksDefault) return MaxDisksDefault;
    return cfg_num_disks;
  endfunction

  function automatic logic [7:0] disk_mask();
    return 8'((9'd1 << active_disks()) - 9'd1);
  endfunction

  function automatic void restart_set();
    col_count   = 0;
    set_invalid = 1'b0;
    set_done    = 1'b0;
    rd_block    = 0;
    rd_disk     = 0;
    rd_bit      = 0;
    read_done   = 1'b0;
  endfunction

  function automatic answer_t compute_column_answer(logic [7:0] bits, logic [7:0] mask,
                                                    logic lastc);
    answer_t     a;
    logic [7:0]  erased;
    logic [7:0]  good;
    logic        x;
    int unsigned cnt;
    int unsigned pos;
    int unsigned d;
    d      = active_disks();
    erased = mask & disk_mask();
    good   = bits & disk_mask() & ~erased;
    if (set_done) restart_set();
    x   = 1'b0;
    cnt = 0;
    pos = 0;
    for (int i = 0; i < d; i++) begin
      if (erased[i]) begin
        cnt++;
        pos = i;
      end else begin
        x ^= good[i];
      end
    end
    if (cnt >= 2) set_invalid = 1'b1;
    else if (cnt == 0) begin
      if (x != cfg_parity_odd) set_invalid = 1'b1;
    end else begin
      good[pos] = x ^ cfg_parity_odd;
    end
    if (col_count < STORE_DEPTH) begin
      column_mirror[col_count] = good;
      col_count++;
    end else begin
      set_invalid = 1'b1;
    end
    a = '{status: STATUS_ACCEPT, nibble: '0, last: 1'b0};
    if (lastc) begin
      set_done = 1'b1;
      if (longint'(col_count) != longint'(cfg_num_blocks) * longint'(cfg_block_bits))
        set_invalid = 1'b1;
      a.status = set_invalid ? STATUS_INVALID : STATUS_VALID;
    end
    return a;
  endfunction

  // step to the next data bit, or past the last block
  function automatic void settle_read_position();
    int unsigned d;
    d = active_disks();
    while (rd_block < cfg_num_blocks) begin
      if (rd_disk >= d) begin
        rd_disk = 0;
        rd_block++;
      end else if (rd_disk == rd_block % d) begin
        rd_disk++;
      end else if (rd_bit >= cfg_block_bits) begin
        rd_bit = 0;
        rd_disk++;
      end else begin
        break;
      end
    end
  endfunction

  function automatic answer_t compute_read_answer();
    answer_t         a;
    longint unsigned col;
    logic            b;
    a = '{status: STATUS_INVALID, nibble: '0, last: 1'b1};
    if (!set_done || set_invalid || read_done) return a;
    for (int k = 0; k < 4; k++) begin
      b = 1'b0;
      settle_read_position();
      if (rd_block < cfg_num_blocks) begin
        col = longint'(rd_block) * cfg_block_bits + rd_bit;
        if (col < STORE_DEPTH) b = column_mirror[int'(col)][rd_disk & 7];
        rd_bit++;
      end
      a.nibble = {a.nibble[NibW-2:0], b};
    end
    settle_read_position();
    if (rd_block >= cfg_num_blocks) read_done = 1'b1;
    a.status = STATUS_NIBBLE;
    a.last   = read_done;
    return a;
  endfunction

  function automatic void make_column(input col_kind_e kind, output logic [7:0] bits,
                                      output logic [7:0] mask);
    int unsigned d;
    int unsigned p;
    d    = active_disks();
    bits = 8'($urandom);
    mask = 8'($urandom) & ~disk_mask();
    p    = $urandom_range(d - 1, 0);
    case (kind)
      COL_CLEAN: begin
        if ((^(bits & disk_mask())) != cfg_parity_odd) bits[p] = ~bits[p];
      end
      COL_ERASE_ONE: mask[p] = 1'b1;
      COL_ERASE_MANY: begin
        mask[p]           = 1'b1;
        mask[(p + 1) % d] = 1'b1;
        mask              = mask | (8'($urandom) & disk_mask());
      end
      COL_BAD_PARITY: begin
        if ((^(bits & disk_mask())) == cfg_parity_odd) bits[p] = ~bits[p];
      end
      default: mask = 8'($urandom);
    endcase
  endfunction

  function automatic col_kind_e pick_kind(input logic broken);
    int unsigned r;
    r = $urandom_range(99, 0);
    if (!broken) return (r < 60) ? COL_CLEAN : COL_ERASE_ONE;
    if (r < 40) return COL_CLEAN;
    if (r < 65) return COL_ERASE_ONE;
    if (r < 80) return COL_ERASE_MANY;
    if (r < 92) return COL_BAD_PARITY;
    return COL_NOISE;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_PARITY_ODD: cfg_parity_odd = data[0];
      CFG_NUM_DISKS:  cfg_num_disks  = data[NumDisksW-1:0];
      CFG_BLOCK_BITS: cfg_block_bits = data[BlkW-1:0];
      CFG_NUM_BLOCKS: cfg_num_blocks = data[BlkW-1:0];
      default: ;
    endcase
  endtask

  task automatic write_settings(input logic po, input int unsigned nd, input int unsigned bb,
                                input int unsigned nb);
    write_reg(CFG_PARITY_ODD, CfgDataW'(po));
    write_reg(CFG_NUM_DISKS, CfgDataW'(nd));
    write_reg(CFG_BLOCK_BITS, CfgDataW'(bb));
    write_reg(CFG_NUM_BLOCKS, CfgDataW'(nb));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_request(input logic rtype, input logic [7:0] bits, input logic [7:0] mask,
                              input logic lastc, output logic ans_last);
    int unsigned gap;
    answer_t     ans;
    gap = $urandom_range(tx_gap_max, 0);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= rtype;
    disk_bits_i   <= bits;
    erased_mask_i <= mask;
    last_column_i <= lastc;
    do @(posedge clk_i); while (!in_ready_o);
    if (rtype == REQ_READ) ans = compute_read_answer();
    else ans = compute_column_answer(bits, mask, lastc);
    pending_answers.push_back(ans);
    sent_items++;
    ans_last = ans.last;
  endtask

  task automatic load_column(input logic [7:0] bits, input logic [7:0] mask, input logic lastc);
    logic unused;
    send_request(REQ_LOAD, bits, mask, lastc, unused);
  endtask

  task automatic load_set(input int unsigned ncols, input logic broken);
    logic [7:0] bits;
    logic [7:0] mask;
    for (int unsigned c = 0; c < ncols; c++) begin
      make_column(pick_kind(broken), bits, mask);
      load_column(bits, mask, c == ncols - 1);
    end
  endtask

  task automatic read_out(input int unsigned extra);
    logic done;
    do send_request(REQ_READ, 8'($urandom), 8'($urandom), 1'($urandom), done); while (!done);
    repeat (extra) send_request(REQ_READ, 8'($urandom), 8'($urandom), 1'($urandom), done);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_answers.size() != 0);
  endtask

  task automatic test_read_before_load();
    logic done;
    send_request(REQ_READ, 8'h00, 8'h00, 1'b0, done);
  endtask

  task automatic test_default_config();
    load_column(8'hF6, 8'h00, 1'b1);
    read_out(1);
  endtask

  task automatic test_erasure_rebuild();
    drain_results();
    write_settings(1'b1, 8, 2, 1);
    load_column(8'hFF, 8'h80, 1'b0);
    load_column(8'h00, 8'h01, 1'b1);
    read_out(1);
  endtask

  task automatic test_bad_columns();
    drain_results();
    write_settings(1'b0, 8, 1, 2);
    load_column(8'h01, 8'h00, 1'b0);
    load_column(8'hFF, 8'hFF, 1'b1);
    read_out(0);
    load_column(8'h00, 8'h03, 1'b0);
    load_column(8'hFF, 8'h00, 1'b1);
    read_out(0);
  endtask

  task automatic test_count_mismatch();
    drain_results();
    write_settings(1'b1, 4, 2, 2);
    load_set(3, 1'b0);
    read_out(0);
    load_set(5, 1'b0);
    read_out(0);
  endtask

  task automatic test_disk_count_range();
    drain_results();
    write_settings(1'b0, 0, 1, 2);
    load_set(2, 1'b0);
    read_out(0);
    drain_results();
    write_settings(1'b1, 15, 1, 1);
    load_set(1, 1'b0);
    read_out(1);
  endtask

  task automatic test_output_stall();
    drain_results();
    write_settings(1'b0, 4, 3, 2);
    hold_off_cycles = 400;
    load_set(6, 1'b0);
    read_out(1);
  endtask

  task automatic test_random_traffic();
    int unsigned first;
    int unsigned nd;
    int unsigned bb;
    int unsigned nb;
    int unsigned ncols;
    int unsigned shape;
    logic        broken;
    logic        done;
    logic [7:0]  bits;
    logic [7:0]  mask;
    first = sent_items;
    while (sent_items - first < RANDOM_ITEMS) begin
      drain_results();
      if ($urandom_range(9, 0) == 0) nd = $urandom_range(1, 0) ? 0 : $urandom_range(15, 9);
      else nd = $urandom_range(8, 1);
      shape = $urandom_range(9, 0);
      case (shape)
        0: begin
          bb = $urandom_range(64, 9);
          nb = $urandom_range(2, 1);
        end
        1: begin
          bb = $urandom_range(2, 1);
          nb = $urandom_range(40, 7);
        end
        2: begin
          bb = $urandom_range(1, 0) ? 0 : $urandom_range(4, 1);
          nb = (bb == 0) ? $urandom_range(4, 1) : 0;
        end
        default: begin
          bb = $urandom_range(8, 1);
          nb = $urandom_range(6, 1);
        end
      endcase
      if ($urandom_range(3, 0) == 0) begin
        tx_gap_max = 0;
        rx_gap_max = 0;
      end else begin
        tx_gap_max = 6;
        rx_gap_max = 6;
      end
      write_settings(1'($urandom), nd, bb, nb);
      repeat ($urandom_range(3, 1)) begin
        ncols  = bb * nb;
        broken = ($urandom_range(6, 0) == 0);
        case ($urandom_range(19, 0))
          0: ncols = ncols + 1;
          1: if (ncols > 1) ncols = ncols - 1;
          default: ;
        endcase
        if (ncols == 0) ncols = $urandom_range(3, 1);
        for (int unsigned c = 0; c < ncols; c++) begin
          if (c > 0 && $urandom_range(49, 0) == 0)
            send_request(REQ_READ, 8'($urandom), 8'($urandom), 1'($urandom), done);
          make_column(pick_kind(broken), bits, mask);
          load_column(bits, mask, (c == ncols - 1) || ($urandom_range(199, 0) == 0));
        end
        read_out($urandom_range(2, 0));
      end
    end
  endtask

  // result side: random stalls after each transfer, plus a long hold-off on request
  initial begin : result_sink
    int unsigned gap;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    out_ready_i <= 1'b1;
    forever begin
      @(posedge clk_i);
      gap = 0;
      if (out_valid_o && out_ready_i) begin
        gap = $urandom_range(rx_gap_max, 0);
      end else if (hold_off_cycles > 0) begin
        gap             = hold_off_cycles;
        hold_off_cycles = 0;
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : answer_check
    answer_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_answers.size() == 0) begin
        $error("unexpected result: status %0d nibble %0h last %0b", status_o, nibble_o, last_o);
        mismatch_count++;
      end else begin
        want = pending_answers.pop_front();
        if (status_o !== want.status) begin
          $error("status expected %0d actual %0d", want.status, status_o);
          mismatch_count++;
        end
        if (nibble_o !== want.nibble) begin
          $error("nibble expected %0h actual %0h", want.nibble, nibble_o);
          mismatch_count++;
        end
        if (last_o !== want.last) begin
          $error("last expected %0b actual %0b", want.last, last_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : cycle_count
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("raid_parity_recover_unit verification failed");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    req_type_i     = REQ_LOAD;
    disk_bits_i    = '0;
    erased_mask_i  = '0;
    last_column_i  = 1'b0;
    cfg_parity_odd = 1'b0;
    cfg_num_disks  = 4'd3;
    cfg_block_bits = 14'd1;
    cfg_num_blocks = 14'd1;
    restart_set();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_read_before_load();
    test_default_config();
    test_erasure_rebuild();
    test_bad_columns();
    test_count_mismatch();
    test_disk_count_range();
    test_output_stall();
    test_random_traffic();
    drain_results();
    repeat (SETTLE_TAIL) @(posedge clk_i);
    if (mismatch_count == 0) $display("raid_parity_recover_unit verification clean");
    else $display("raid_parity_recover_unit verification failed");
    $finish;
  end

endmodule
